[rtl/mpq_pkg.sv]
// Shared constants and types for the unsorted max priority queue.
`default_nettype none

package mpq_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths
  localparam int KEY_W  = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  // input and output bus widths
  localparam int S_DATA_W = 32;
  localparam int S_USER_W = 8;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 8;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/max_priority_queue_unsorted_unit.sv]
// Top level: max priority queue over an unsorted key store with a serial max scan.
`default_nettype none

// Channel  | Dir | Fields
// s_axis   | in  | tdata: key_in[31:0]; tuser: func[1:0]
// m_axis   | out | tdata: key_out[31:0], fill[36:32]; tuser: status[1:0]
//
// Insert, rejected ops and unused codes: result valid in the cycle after the transfer.
// Remove and peek over n held keys: result registered once the last entry is folded in; the
// single comparator walks the store one entry per cycle through its read port.
// One item at a time: s_tready is high only when idle and no result is pending.
// A stalled result holds on m_tdata/m_tuser until taken.
// Reset clears the fill count and the sequencer; store contents are left as is.

module max_priority_queue_unsorted_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  input  wire logic [mpq_pkg::S_DATA_W-1:0] s_tdata,  // key_in[31:0]
  input  wire logic [mpq_pkg::S_USER_W-1:0] s_tuser,  // func[1:0], zeros above
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [mpq_pkg::M_DATA_W-1:0] m_tdata,  // key_out[31:0], fill[36:32], zeros
  output      logic [mpq_pkg::M_USER_W-1:0] m_tuser   // status[1:0], zeros above
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                   state;
  mpq_pkg::cnt_t                count;
  logic [mpq_pkg::FUNC_W-1:0]   op;

  // scan read side
  mpq_pkg::idx_t                rd_idx;
  logic                         rd_busy;
  mpq_pkg::key_t                rd_data;
  logic                         data_vld;
  mpq_pkg::idx_t                data_idx;

  // running maximum
  mpq_pkg::key_t                best_key;
  mpq_pkg::idx_t                best_idx;
  mpq_pkg::key_t                best_key_next;
  mpq_pkg::idx_t                best_idx_next;

  // result register
  logic [mpq_pkg::STAT_W-1:0]   out_status;
  mpq_pkg::key_t                out_key;
  logic [mpq_pkg::FILL_W-1:0]   out_fill;

  // store write port
  logic                         wr_en;
  mpq_pkg::idx_t                wr_addr;
  mpq_pkg::key_t                wr_data;

  mpq_pkg::key_t                key_mem [mpq_pkg::DEPTH];

  logic [mpq_pkg::FUNC_W-1:0]   in_func;
  mpq_pkg::key_t                in_key;
  logic                         in_xfer;
  mpq_pkg::cnt_t                cnt_m1;
  mpq_pkg::idx_t                last_idx;
  logic                         take_cur;
  logic                         scan_last;
  logic                         is_full;

  assign in_func  = s_tuser[mpq_pkg::FUNC_W-1:0];
  assign in_key   = $signed(s_tdata[mpq_pkg::KEY_W-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign cnt_m1   = count - mpq_pkg::CNT_W'(1);
  assign last_idx = cnt_m1[mpq_pkg::IDX_W-1:0];
  assign is_full  = (count == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));

  // compare stage: later entries win ties
  assign take_cur      = (data_idx == '0) || !(best_key > rd_data);
  assign best_key_next = take_cur ? rd_data  : best_key;
  assign best_idx_next = take_cur ? data_idx : best_idx;
  assign scan_last     = data_vld && (data_idx == last_idx);

  // write port select: append on insert, back-fill the hole on remove
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[mpq_pkg::IDX_W-1:0];
    wr_data = in_key;
    if (state == ST_IDLE) begin
      wr_en = in_xfer && (in_func == mpq_pkg::FN_INSERT) && !is_full;
    end else if (state == ST_SCAN) begin
      wr_en   = scan_last && (op == mpq_pkg::FN_REMOVE);
      wr_addr = best_idx_next;
      wr_data = rd_data;
    end
  end

  // key store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rd_data <= key_mem[rd_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_busy  <= 1'b0;
      data_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            op         <= in_func;
            out_key    <= '0;
            out_status <= mpq_pkg::STAT_OK;
            out_fill   <= mpq_pkg::FILL_W'(count);
            state      <= ST_OUT;
            if (in_func == mpq_pkg::FN_INSERT) begin
              if (is_full) begin
                out_status <= mpq_pkg::STAT_FULL;
              end else begin
                count    <= count + mpq_pkg::CNT_W'(1);
                out_fill <= mpq_pkg::FILL_W'(count + mpq_pkg::CNT_W'(1));
              end
            end else if (in_func == mpq_pkg::FN_REMOVE || in_func == mpq_pkg::FN_PEEK) begin
              if (count == '0) begin
                out_status <= mpq_pkg::STAT_EMPTY;
              end else begin
                rd_idx  <= '0;
                rd_busy <= 1'b1;
                state   <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          // issue one read per cycle
          data_vld <= rd_busy;
          data_idx <= rd_idx;
          if (rd_busy) begin
            if (rd_idx == last_idx) begin
              rd_busy <= 1'b0;
            end else begin
              rd_idx <= rd_idx + mpq_pkg::IDX_W'(1);
            end
          end
          // fold in the returned key
          if (data_vld) begin
            best_key <= best_key_next;
            best_idx <= best_idx_next;
          end
          if (scan_last) begin
            data_vld <= 1'b0;
            out_key  <= best_key_next;
            state    <= ST_OUT;
            if (op == mpq_pkg::FN_REMOVE) begin
              count    <= cnt_m1;
              out_fill <= mpq_pkg::FILL_W'(cnt_m1);
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result bus
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(mpq_pkg::M_DATA_W - mpq_pkg::KEY_W - mpq_pkg::FILL_W){1'b0}},
                     out_fill, out_key};
  assign m_tuser  = {{(mpq_pkg::M_USER_W - mpq_pkg::STAT_W){1'b0}}, out_status};

endmodule

`default_nettype wire

[sim/tb_max_priority_queue_unsorted_unit.sv]
// Testbench for the unsorted max priority queue: predicts every result and checks the stream.
`default_nettype none

module tb_max_priority_queue_unsorted_unit;
  import mpq_pkg::*;

  // code with no operation behind it; the block must leave the store alone
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int PHASES         = 18;
  localparam int PHASE_LEN      = 40;
  localparam int CALM_TAIL      = 50;    // last items run with no idling
  localparam int HOLD_AFTER     = 250;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    key_t              key;
  } queue_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    key_t              key;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // key_in[31:0]
  logic [S_USER_W-1:0] s_tuser = '0;   // func[1:0], zeros above
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // key_out[31:0], fill[36:32], zeros
  logic [M_USER_W-1:0] m_tuser;        // status[1:0], zeros above

  queue_op_t     op_queue[$];
  queue_result_t expected_results[$];

  // shadow copy of the queue contents
  key_t shadow_keys[DEPTH];
  int   held = 0;

  bit stim_ready = 1'b0;
  int error_count = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  max_priority_queue_unsorted_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // apply one operation to the shadow store, return the result it should give
  function automatic queue_result_t apply_queue_op(input queue_op_t op);
    queue_result_t r;
    int            best;
    r.status = STAT_OK;
    r.key    = '0;
    case (op.func)
      FN_INSERT: begin
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_keys[held] = op.key;
          held++;
        end
      end
      FN_REMOVE, FN_PEEK: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // later entries win ties
          best = 0;
          for (int i = 1; i < held; i++)
            if (shadow_keys[i] >= shadow_keys[best]) best = i;
          r.key = shadow_keys[best];
          if (op.func == FN_REMOVE) begin
            held--;
            shadow_keys[best] = shadow_keys[held];
          end
        end
      end
      default: ;
    endcase
    r.fill = FILL_W'(held);
    return r;
  endfunction

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 9))
      0, 1: k = key_t'($urandom_range(0, 8)) - 4;   // narrow range, many ties
      2: begin
        case ($urandom_range(0, 5))
          0: k = 32'h8000_0000;
          1: k = 32'h7fff_ffff;
          2: k = 32'h0000_0000;
          3: k = 32'hffff_ffff;
          4: k = 32'h8000_0001;
          default: k = 32'h7fff_fffe;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic add_op(input logic [FUNC_W-1:0] func, input key_t key);
    queue_op_t op;
    op.func = func;
    op.key  = key;
    op_queue.push_back(op);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("ERROR %s: got %0h, expected %0h (result %0d)", what, got, want, results_seen);
    error_count++;
  endtask

  // stimulus and end of run
  initial begin
    int mode;
    int r;
    logic [FUNC_W-1:0] func;

    // empty queue, extreme keys, equal maxima, unused code
    add_op(FN_REMOVE, 32'hffff_ffff);
    add_op(FN_PEEK, 32'h0000_0000);
    add_op(FN_UNUSED, 32'h5a5a_5a5a);
    add_op(FN_INSERT, 32'h8000_0000);
    add_op(FN_PEEK, 32'ha5a5_a5a5);
    add_op(FN_INSERT, 32'h7fff_ffff);
    add_op(FN_INSERT, 32'h0000_0000);
    add_op(FN_INSERT, 32'hffff_ffff);
    add_op(FN_INSERT, 32'h7fff_ffff);
    add_op(FN_PEEK, 32'hffff_ffff);
    add_op(FN_UNUSED, 32'h0000_0000);
    repeat (6) add_op(FN_REMOVE, $urandom);
    add_op(FN_PEEK, $urandom);

    // random phases that push toward full, toward empty, or stay mixed
    for (int p = 0; p < PHASES; p++) begin
      mode = $urandom_range(0, 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: func = (r < 75) ? FN_INSERT : (r < 85) ? FN_REMOVE : (r < 97) ? FN_PEEK : FN_UNUSED;
          1: func = (r < 20) ? FN_INSERT : (r < 80) ? FN_REMOVE : (r < 97) ? FN_PEEK : FN_UNUSED;
          default:
            func = (r < 45) ? FN_INSERT : (r < 75) ? FN_REMOVE : (r < 96) ? FN_PEEK : FN_UNUSED;
        endcase
        add_op(func, pick_key());
      end
    end
    stim_ready = 1'b1;

    while (rst) @(posedge clk);
    while (op_queue.size() > 0 || s_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // every accepted operation must have produced its result
    if (expected_results.size() != 0)
      report_mismatch("results missing, count", 64'(expected_results.size()), 64'd0);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // sender: offers queued ops with random gaps, predicts on each transfer
  always @(posedge clk) begin : drive_ops
    queue_op_t     op;
    queue_result_t res;
    logic          nxt_valid;
    int            gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        op.func = s_tuser[FUNC_W-1:0];
        op.key  = s_tdata;
        res = apply_queue_op(op);
        expected_results.push_back(res);
        ops_sent++;
        nxt_valid = 1'b0;
        if (op_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 19);
      end
      if (!nxt_valid && stim_ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_queue.size() > 0) begin
          op = op_queue.pop_front();
          s_tdata   <= op.key;
          s_tuser   <= {{(S_USER_W-FUNC_W){1'b0}}, op.func};
          nxt_valid = 1'b1;
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // receiver: checks each transfer against the oldest prediction, stalls at random
  always @(posedge clk) begin : watch_results
    queue_result_t want;
    logic [STAT_W-1:0] got_status;
    key_t              got_key;
    logic [FILL_W-1:0] got_fill;
    logic              rdy;
    int                stall_left;
    int                hold_left;
    bit                hold_done;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = m_tuser[STAT_W-1:0];
        got_key    = m_tdata[KEY_W-1:0];
        got_fill   = m_tdata[KEY_W +: FILL_W];
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, key", 64'(got_key), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got_status !== want.status) report_mismatch("status", 64'(got_status),
                                                          64'(want.status));
          if (got_key !== want.key) report_mismatch("key_out", 64'(got_key), 64'(want.key));
          if (got_fill !== want.fill) report_mismatch("fill", 64'(got_fill), 64'(want.fill));
        end
      end

      // long hold once, so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (stim_ready && op_queue.size() >= CALM_TAIL && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

[files.f]
rtl/mpq_pkg.sv
rtl/max_priority_queue_unsorted_unit.sv
sim/tb_max_priority_queue_unsorted_unit.sv
